>>> rtl/core/srce_pkg.sv
`default_nettype none

package srce_pkg;

    // event codes carried on the action field
    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_LOST  = 3'd1;
    localparam logic [2:0] ACT_POSE  = 3'd2;
    localparam logic [2:0] ACT_WHEEL = 3'd3;
    localparam logic [2:0] ACT_TICK  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_ACCUM  = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    localparam int RATIO_W = 32;
    localparam int FRAC_W  = 16;
    localparam int TICK_W  = 32;
    localparam int THR_W   = 14;
    localparam int PROD_W  = RATIO_W + THR_W;

    localparam logic [THR_W-1:0]  SCALE_K      = 14'd10000;
    localparam logic [THR_W-1:0]  THRESH_RESET = 14'd100;
    localparam logic [TICK_W-1:0] WINDOW_RESET = 32'd100;

endpackage

`default_nettype wire

>>> rtl/core/srce_step_unit.sv
`default_nettype none

module srce_step_unit #(
    parameter int POS_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire logic signed [POS_WIDTH-1:0] i_cur_x,
    input  wire logic signed [POS_WIDTH-1:0] i_cur_y,
    input  wire logic signed [POS_WIDTH-1:0] i_cur_z,
    input  wire logic signed [POS_WIDTH-1:0] i_prev_x,
    input  wire logic signed [POS_WIDTH-1:0] i_prev_y,
    input  wire logic signed [POS_WIDTH-1:0] i_prev_z,
    output logic                        o_done,
    output logic [POS_WIDTH:0]          o_len
);
    import srce_pkg::*;

    localparam int MW = POS_WIDTH + 1;
    localparam int SW = 2 * MW;
    localparam int RW = POS_WIDTH + 3;
    localparam int CW = $clog2(MW + 1);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_LOAD = 4'b0010,
        U_SQ   = 4'b0100,
        U_RT   = 4'b1000
    } t_ustate;

    t_ustate           r_state;
    logic [MW-1:0]     r_mag [3];
    logic [1:0]        r_axis;
    logic [CW-1:0]     r_cnt;
    logic [SW-1:0]     r_mcand;
    logic [MW-1:0]     r_mplier;
    logic [SW-1:0]     r_sum;
    logic [RW-1:0]     r_rem;
    logic [MW-1:0]     r_root;
    logic              r_done;

    logic signed [MW-1:0] w_dx, w_dy, w_dz;
    logic [RW-1:0]     w_cur;
    logic [RW-1:0]     w_trial;
    logic              w_ge;

    function automatic logic [MW-1:0] f_abs(input logic signed [MW-1:0] d);
        f_abs = d[MW-1] ? MW'(-d) : MW'(d);
    endfunction

    always_comb begin
        w_dx    = MW'({i_cur_x[POS_WIDTH-1], i_cur_x}) - MW'({i_prev_x[POS_WIDTH-1], i_prev_x});
        w_dy    = MW'({i_cur_y[POS_WIDTH-1], i_cur_y}) - MW'({i_prev_y[POS_WIDTH-1], i_prev_y});
        w_dz    = MW'({i_cur_z[POS_WIDTH-1], i_cur_z}) - MW'({i_prev_z[POS_WIDTH-1], i_prev_z});
        w_cur   = {r_rem[RW-3:0], r_sum[SW-1:SW-2]};
        w_trial = {r_root, 2'b01};
        w_ge    = (w_cur >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_mag[0] <= f_abs(w_dx);
                        r_mag[1] <= f_abs(w_dy);
                        r_mag[2] <= f_abs(w_dz);
                        r_axis   <= 2'd0;
                        r_sum    <= '0;
                        r_state  <= U_LOAD;
                    end
                end
                U_LOAD: begin
                    r_mcand  <= SW'(r_mag[r_axis]);
                    r_mplier <= r_mag[r_axis];
                    r_cnt    <= '0;
                    r_state  <= U_SQ;
                end
                U_SQ: begin
                    // shift-add square, accumulated over the three axes
                    if (r_mplier[0]) begin
                        r_sum <= r_sum + r_mcand;
                    end
                    r_mcand  <= {r_mcand[SW-2:0], 1'b0};
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MW - 1)) begin
                        r_cnt <= '0;
                        if (r_axis == 2'd2) begin
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_state <= U_RT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= U_LOAD;
                        end
                    end
                end
                U_RT: begin
                    // restoring square root, two radicand bits a step
                    r_sum  <= {r_sum[SW-3:0], 2'b00};
                    r_rem  <= w_ge ? (w_cur - w_trial) : w_cur;
                    r_root <= {r_root[MW-2:0], w_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MW - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_len  = r_root;

endmodule

`default_nettype wire

>>> rtl/core/srce_divider.sv
`default_nettype none

module srce_divider #(
    parameter int DIST_WIDTH = 48
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire [DIST_WIDTH-1:0]   i_num,
    input  wire [DIST_WIDTH-1:0]   i_den,
    output logic                   o_done,
    output logic [31:0]            o_ratio
);
    import srce_pkg::*;

    localparam int NW = DIST_WIDTH + FRAC_W;
    localparam int CW = $clog2(NW + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [NW-1:0]         r_q;
    logic [DIST_WIDTH:0]   r_rem;
    logic [DIST_WIDTH-1:0] r_den;

    logic [DIST_WIDTH:0]   w_cur;
    logic                  w_ge;

    always_comb begin
        w_cur = {r_rem[DIST_WIDTH-1:0], r_q[NW-1]};
        w_ge  = (w_cur >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_q    <= {i_num, {FRAC_W{1'b0}}};
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end else begin
            r_rem <= w_ge ? (w_cur - {1'b0, r_den}) : w_cur;
            r_q   <= {r_q[NW-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // zero divisor gives an all-ones quotient, caught with the overflow
    assign o_ratio = (|r_q[NW-1:RATIO_W]) ? '0 : r_q[RATIO_W-1:0];
    assign o_done  = r_done;

endmodule

`default_nettype wire

>>> rtl/core/scale_ratio_convergence_estimator.sv
// Scale ratio convergence estimator.
// Input channel (i_in_valid / o_in_ready) carries one event per item: start,
// lost, visual pose, wheel position or tick. Every item gives exactly one
// result on the output channel (o_out_valid / i_out_ready): o_published and,
// when set, the converged ratio in unsigned Q16.16.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
// users must write it only while the block is idle; the block leaves that to them.
// Work per item, from accept to result loaded:
//   start, lost, tick without evaluation, unused codes: straight to the output
//   pose or wheel step: runs the bit-serial squarer and the square root of the
//     step unit, then the output state
//   tick with evaluation: runs the one-bit-a-cycle divider, then the multiply
//     and compare states, then the output state
// The block takes one item at a time; o_in_ready is low while an item is in
// work. A finished result sits in the output register while the next item
// is taken; if the receiver stalls, the following result waits until the
// register empties. Reset clears the tracking state, loads register defaults.
`default_nettype none

module scale_ratio_convergence_estimator #(
    parameter int POS_WIDTH  = 32,
    parameter int DIST_WIDTH = 48
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [2:0]                    i_action,
    input  wire                          i_flag_value,
    input  wire logic signed [POS_WIDTH-1:0] i_pos_x,
    input  wire logic signed [POS_WIDTH-1:0] i_pos_y,
    input  wire logic signed [POS_WIDTH-1:0] i_pos_z,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_published,
    output logic [31:0]                  o_ratio_out,
    input  wire                          i_cfg_we,
    input  wire [1:0]                    i_cfg_idx,
    input  wire [31:0]                   i_cfg_data
);
    import srce_pkg::*;

    localparam int AW = ((DIST_WIDTH > POS_WIDTH + 1) ? DIST_WIDTH : POS_WIDTH + 1) + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_STEP = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_CMP  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                r_state;
    logic                  r_accum;
    logic [THR_W-1:0]      r_thresh;
    logic [TICK_W-1:0]     r_window;
    logic                  r_started;
    logic                  r_lost;
    logic [POS_WIDTH-1:0]  r_prev_vis [3];
    logic [POS_WIDTH-1:0]  r_prev_whl [3];
    logic [DIST_WIDTH-1:0] r_vis_dist;
    logic [DIST_WIDTH-1:0] r_whl_dist;
    logic [RATIO_W-1:0]    r_old_ratio;
    logic [TICK_W-1:0]     r_elapsed;
    logic                  r_is_wheel;
    logic [RATIO_W-1:0]    r_new_ratio;
    logic [PROD_W-1:0]     r_pa;
    logic [PROD_W-1:0]     r_pb;
    logic                  r_pub;
    logic                  r_out_valid;
    logic                  r_out_pub;
    logic [RATIO_W-1:0]    r_out_ratio;

    logic                  w_accept_in;
    logic                  w_step_start;
    logic                  w_div_start;
    logic                  w_step_done;
    logic                  w_div_done;
    logic [POS_WIDTH:0]    w_len;
    logic [RATIO_W-1:0]    w_div_ratio;
    logic [TICK_W-1:0]     w_tick_next;
    logic                  w_eval;
    logic [RATIO_W-1:0]    w_diff;
    logic [AW-1:0]         w_dsum;
    logic [DIST_WIDTH-1:0] w_dsat;
    logic                  w_pass;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept_in = i_in_valid && o_in_ready;

    always_comb begin
        w_tick_next  = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
        w_eval       = r_started && !r_lost && (w_tick_next > r_window);
        w_step_start = w_accept_in && ((i_action == ACT_POSE) || (i_action == ACT_WHEEL));
        w_div_start  = w_accept_in && (i_action == ACT_TICK) && w_eval;
        w_diff       = (r_old_ratio > r_new_ratio) ? r_old_ratio - r_new_ratio
                                                   : r_new_ratio - r_old_ratio;
        w_dsum       = AW'(r_is_wheel ? r_whl_dist : r_vis_dist) + AW'(w_len);
        // saturate the distance at all ones
        w_dsat       = (|w_dsum[AW-1:DIST_WIDTH]) ? '1 : w_dsum[DIST_WIDTH-1:0];
        w_pass       = (r_pa < r_pb);
    end

    srce_step_unit #(
        .POS_WIDTH (POS_WIDTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_step_start),
        .i_cur_x  (i_pos_x),
        .i_cur_y  (i_pos_y),
        .i_cur_z  (i_pos_z),
        .i_prev_x ((i_action == ACT_WHEEL) ? r_prev_whl[0] : r_prev_vis[0]),
        .i_prev_y ((i_action == ACT_WHEEL) ? r_prev_whl[1] : r_prev_vis[1]),
        .i_prev_z ((i_action == ACT_WHEEL) ? r_prev_whl[2] : r_prev_vis[2]),
        .o_done   (w_step_done),
        .o_len    (w_len)
    );

    srce_divider #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_vis_dist),
        .i_den   (r_whl_dist),
        .o_done  (w_div_done),
        .o_ratio (w_div_ratio)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum  <= 1'b0;
            r_thresh <= THRESH_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACCUM:  r_accum  <= i_cfg_data[0];
                REG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                REG_WINDOW: r_window <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_lost      <= 1'b0;
            r_vis_dist  <= '0;
            r_whl_dist  <= '0;
            r_old_ratio <= '0;
            r_elapsed   <= '0;
            r_pub       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_prev_vis[i] <= '0;
                r_prev_whl[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept_in) begin
                        r_pub   <= 1'b0;
                        r_state <= S_OUT;
                        priority case (i_action)
                            ACT_START: begin
                                if (i_flag_value) begin
                                    r_started   <= 1'b1;
                                    r_elapsed   <= '0;
                                    r_old_ratio <= '0;
                                    r_vis_dist  <= '0;
                                    r_whl_dist  <= '0;
                                end
                            end
                            ACT_LOST: r_lost <= i_flag_value;
                            ACT_POSE: begin
                                r_prev_vis[0] <= i_pos_x;
                                r_prev_vis[1] <= i_pos_y;
                                r_prev_vis[2] <= i_pos_z;
                                r_is_wheel    <= 1'b0;
                                r_state       <= S_STEP;
                            end
                            ACT_WHEEL: begin
                                r_prev_whl[0] <= i_pos_x;
                                r_prev_whl[1] <= i_pos_y;
                                r_prev_whl[2] <= i_pos_z;
                                r_is_wheel    <= 1'b1;
                                r_state       <= S_STEP;
                            end
                            ACT_TICK: begin
                                r_elapsed <= w_tick_next;
                                if (w_eval) begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_STEP: begin
                    if (w_step_done) begin
                        if (!r_lost) begin
                            if (r_is_wheel) begin
                                r_whl_dist <= w_dsat;
                            end else begin
                                r_vis_dist <= w_dsat;
                            end
                        end
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_new_ratio <= w_div_ratio;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pa    <= PROD_W'(w_diff) * PROD_W'(SCALE_K);
                    r_pb    <= PROD_W'(r_thresh) * PROD_W'(r_old_ratio);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_elapsed <= '0;
                    if (w_pass) begin
                        r_pub       <= 1'b1;
                        r_old_ratio <= '0;
                        r_vis_dist  <= '0;
                        r_whl_dist  <= '0;
                        r_started   <= 1'b0;
                        r_lost      <= 1'b0;
                    end else begin
                        r_old_ratio <= r_new_ratio;
                        if (!r_accum) begin
                            r_vis_dist <= '0;
                            r_whl_dist <= '0;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pub   <= r_pub;
                        r_out_ratio <= r_pub ? r_new_ratio : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_published = r_out_pub;
    assign o_ratio_out = r_out_ratio;

    a_item_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept_in |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_eval_only_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_started && !r_lost))
        else $error("evaluation while not started or lost");

    a_publish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) && w_pass) |=>
            (!r_started && (r_vis_dist == '0) && (r_old_ratio == '0)))
        else $error("publish did not clear state");

endmodule

`default_nettype wire
